FILE: src/modexp_pkg.sv
// ---------------------------------------------------------------------------
// modexp_pkg
// Shared width, controller states and control/status bundles.
// ---------------------------------------------------------------------------
package modexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_START,
        ST_RED_RUN,
        ST_SQR_START,
        ST_SQR_RUN,
        ST_MUL_START,
        ST_MUL_RUN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        SEL_REDUCE,
        SEL_SQUARE,
        SEL_MULT
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     mul_step;
        logic     exp_shift;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic skip;
        logic mul_last;
        logic exp_bit;
        logic exp_last;
        logic out_free;
    } ctrl_status_t;

endpackage

FILE: src/modexp_ctrl.sv
// ---------------------------------------------------------------------------
// modexp_ctrl
// Sequencer for reduce, square and multiply passes over the exponent bits.
// ---------------------------------------------------------------------------
module modexp_ctrl
    import modexp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.skip ? ST_FINISH : ST_RED_START;
                end
            end
            ST_RED_START: state_next = ST_RED_RUN;
            ST_RED_RUN:
            begin
                if (status.mul_last)
                begin
                    state_next = ST_SQR_START;
                end
            end
            ST_SQR_START: state_next = ST_SQR_RUN;
            ST_SQR_RUN:
            begin
                if (status.mul_last)
                begin
                    if (status.exp_bit)
                    begin
                        state_next = ST_MUL_START;
                    end
                    else
                    begin
                        state_next = status.exp_last ? ST_FINISH : ST_SQR_START;
                    end
                end
            end
            ST_MUL_START: state_next = ST_MUL_RUN;
            ST_MUL_RUN:
            begin
                if (status.mul_last)
                begin
                    state_next = status.exp_last ? ST_FINISH : ST_SQR_START;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.mul_sel = SEL_REDUCE;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_RED_START:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_REDUCE;
            end
            ST_RED_RUN:   cmd.mul_step = 1'b1;
            ST_SQR_START:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_SQUARE;
            end
            ST_SQR_RUN:
            begin
                cmd.mul_step  = 1'b1;
                // advance the exponent when no multiply pass follows
                cmd.exp_shift = status.mul_last && !status.exp_bit;
            end
            ST_MUL_START:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_MULT;
            end
            ST_MUL_RUN:
            begin
                cmd.mul_step  = 1'b1;
                cmd.exp_shift = status.mul_last;
            end
            ST_FINISH:    cmd.out_load = status.out_free;
            default:      cmd = '0;
        endcase
    end

endmodule

FILE: src/modexp_datapath.sv
// ---------------------------------------------------------------------------
// modexp_datapath
// Modulus register, bit-serial modular multiplier and result register.
// ---------------------------------------------------------------------------
module modexp_datapath
    import modexp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [WIDTH-1:0]   cfg_data,
    input  logic [WIDTH-1:0]   base_value,
    input  logic [WIDTH-1:0]   exponent_value,
    input  ctrl_cmd_t          cmd,
    output ctrl_status_t       status,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [WIDTH-1:0]   residue
);

    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] e_reg;
    logic [CNT_W-1:0] ecnt_reg;
    logic             zexp_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] y_reg;
    logic [WIDTH-1:0] r_reg;
    logic [CNT_W-1:0] mcnt_reg;
    mul_sel_t         msel_reg;
    logic             out_valid_reg;
    logic [WIDTH-1:0] residue_reg;

    logic [WIDTH-1:0] one_mod;
    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   sum_red;
    logic [WIDTH-1:0] r_next;
    logic             mul_done;

    assign one_mod = (n_reg == WIDTH'(1)) ? '0 : WIDTH'(1);

    // one interleaved step: r = (2r + ybit*x) mod n, both terms below n
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, n_reg}) ? dbl - {1'b0, n_reg} : dbl;
        sum     = dbl_red + (y_reg[WIDTH-1] ? {1'b0, x_reg} : '0);
        sum_red = (sum >= {1'b0, n_reg}) ? sum - {1'b0, n_reg} : sum;
        r_next  = sum_red[WIDTH-1:0];
    end

    assign mul_done = cmd.mul_step && (mcnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= WIDTH'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                n_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            b_reg    <= base_value;
            e_reg    <= exponent_value;
            ecnt_reg <= CNT_W'(WIDTH - 1);
            zexp_reg <= (exponent_value == '0);
        end
        else if (cmd.exp_shift)
        begin
            e_reg    <= {e_reg[WIDTH-2:0], 1'b0};
            ecnt_reg <= ecnt_reg - CNT_W'(1);
        end

        if (cmd.mul_start)
        begin
            r_reg    <= '0;
            mcnt_reg <= CNT_W'(WIDTH - 1);
            msel_reg <= cmd.mul_sel;
            case (cmd.mul_sel)
                SEL_REDUCE:
                begin
                    x_reg <= one_mod;
                    y_reg <= b_reg;
                end
                SEL_SQUARE:
                begin
                    x_reg <= acc_reg;
                    y_reg <= acc_reg;
                end
                default:
                begin
                    x_reg <= b_reg;
                    y_reg <= acc_reg;
                end
            endcase
        end
        else if (cmd.mul_step)
        begin
            r_reg    <= r_next;
            y_reg    <= {y_reg[WIDTH-2:0], 1'b0};
            mcnt_reg <= mcnt_reg - CNT_W'(1);
        end

        // commit the finished product to its destination
        if (mul_done)
        begin
            if (msel_reg == SEL_REDUCE)
            begin
                b_reg   <= r_next;
                acc_reg <= one_mod;
            end
            else
            begin
                acc_reg <= r_next;
            end
        end

        if (cmd.out_load)
        begin
            if (zexp_reg)
            begin
                residue_reg <= WIDTH'(1);
            end
            else if (n_reg == '0)
            begin
                residue_reg <= '0;
            end
            else
            begin
                residue_reg <= acc_reg;
            end
        end
    end

    assign status.skip     = (exponent_value == '0) || (n_reg == '0);
    assign status.mul_last = (mcnt_reg == '0);
    assign status.exp_bit  = e_reg[WIDTH-1];
    assign status.exp_last = (ecnt_reg == '0);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign residue   = residue_reg;

endmodule

FILE: src/modular_exponentiation.sv
// ---------------------------------------------------------------------------
// modular_exponentiation
// Square-and-multiply modular exponentiation against a configured modulus.
// ---------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready) writes the modulus; ready is always
//   high. Write it only while no transaction is in flight.
//   in channel (in_valid/in_stall) takes base_value and exponent_value; a
//   transaction is accepted when valid is high and stall is low. Stall is
//   low only while the sequencer is idle, one item at a time.
//   out channel (out_valid/out_stall) returns residue from an output
//   register; it holds while the receiver stalls, and the next input
//   transaction may be accepted meanwhile.
// Passes: the bit-serial multiplier forms one modular product per pass. An
//   item costs one reduction pass plus one square per exponent bit and one
//   multiply per set bit. Zero exponent or zero modulus skips all passes.
// Reset: modulus returns to 1, no output is pending.
// ---------------------------------------------------------------------------
module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [WIDTH-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [WIDTH-1:0] base_value,
    input  logic [WIDTH-1:0] exponent_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] residue
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    modexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    modexp_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .residue        (residue)
    );

endmodule

FILE: dv/modexp_checker.sv
// ---------------------------------------------------------------------------
// modexp_checker
// Watches the config, input and output channels of the exponentiation
// block, predicts each residue by square-and-multiply and compares.
// ---------------------------------------------------------------------------
module modexp_checker
    import modexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [WIDTH-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [WIDTH-1:0] base_value,
    input  logic [WIDTH-1:0] exponent_value,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [WIDTH-1:0] residue,
    output int               err_count,
    output int               pending,
    output int               residues_seen
);

    logic [WIDTH-1:0] key_modulus;
    logic [WIDTH-1:0] residue_q[$];

    function automatic logic [WIDTH-1:0] power_mod(logic [WIDTH-1:0] b,
                                                   logic [31:0] e,
                                                   logic [WIDTH-1:0] n);
        logic [2*WIDTH-1:0] acc;
        logic [2*WIDTH-1:0] rb;
        if (e == 0)
            return 1;
        if (n == 0)
            return 0;
        rb  = b % n;
        acc = 1 % n;
        for (int i = 31; i >= 0; i--)
        begin
            acc = (acc * acc) % n;
            if (e[i])
                acc = (acc * rb) % n;
        end
        return acc[WIDTH-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [WIDTH-1:0] got,
                                   logic [WIDTH-1:0] want);
        $display("MISMATCH %s: got %h want %h at cycle time %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_modulus   <= 1;
            err_count     = 0;
            residues_seen = 0;
            residue_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                residue_q.push_back(power_mod(base_value, exponent_value, key_modulus));
            if (out_valid && !out_stall)
            begin
                residues_seen++;
                if (residue_q.size() == 0)
                    report_mismatch("unexpected residue", residue, '0);
                else if (residue !== residue_q[0])
                begin
                    report_mismatch("residue", residue, residue_q[0]);
                    void'(residue_q.pop_front());
                end
                else
                    void'(residue_q.pop_front());
            end
            if (cfg_valid && cfg_ready)
                key_modulus <= cfg_data;
        end
        pending = residue_q.size();
    end

endmodule

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives keys and base/exponent transactions into the modular exponentiation
// block under varied idling and stall patterns; the checker judges results.
// ---------------------------------------------------------------------------
module tb_top;
    import modexp_pkg::*;

    logic             clk = 0;
    logic             rst_n = 0;
    logic             cfg_valid = 0;
    logic             cfg_ready;
    logic [WIDTH-1:0] cfg_data = 0;
    logic             in_valid = 0;
    logic             in_stall;
    logic [WIDTH-1:0] base_value = 0;
    logic [WIDTH-1:0] exponent_value = 0;
    logic             out_valid;
    logic             out_stall = 0;
    logic [WIDTH-1:0] residue;
    int               err_count, pending, residues_seen;
    int               send_idle_pct = 0, stall_pct = 0;
    bit               hold_off = 0;
    int               cycle_count = 0;
    int               items_sent = 0;
    int               keys_written = 0;

    localparam int CYCLE_LIMIT = 8_000_000;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    modular_exponentiation dut (.*);

    modexp_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall, random or a long hold-off
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);

    task automatic write_key(logic [WIDTH-1:0] n);
        cfg_valid <= 1;
        cfg_data  <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        keys_written++;
    endtask

    // valid stays high into the next transaction unless the sender idles
    task automatic send_pair(logic [WIDTH-1:0] b, logic [WIDTH-1:0] e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid       <= 1;
        base_value     <= b;
        exponent_value <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [WIDTH-1:0] pick_word();
        case ($urandom_range(5))
            0: return 0;
            1: return '1;
            2: return $urandom_range(15);
            3: return '1 - $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WIDTH-1:0] pick_exponent();
        case ($urandom_range(7))
            0: return 0;
            1: return '1;
            2: return $urandom_range(3);
            3: return 32'd65537;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [WIDTH-1:0] keys[6];
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset modulus of one, then directed extremes
        send_pair(5, 0);
        send_pair(5, 3);
        send_pair('1, '1);
        drain();
        write_key(0);
        send_pair(7, 0);
        send_pair(7, 9);
        drain();
        write_key('1);
        send_pair('1, '1);
        send_pair('1 - 1, 2);
        send_pair(0, 5);
        send_pair(0, 0);
        send_pair(2, 31);
        send_pair(3, 32'h8000_0000);
        drain();
        write_key(32'd3233);
        send_pair(65, 17);
        send_pair(2790, 2753);
        send_pair(3233, 1);
        drain();
        write_key(32'h8000_0000);
        send_pair(3, '1);
        send_pair(32'h8000_0001, 2);
        drain();

        keys = '{32'd2, 32'hFFFF_FFFB, 32'd97, 32'h8000_0000, 32'd1, 32'd0};
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 47; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 47; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            write_key(ph < 6 ? keys[ph] : (ph == 6 ? pick_word() : $urandom | 1));
            if (ph == 2)
            begin
                // long hold-off while inputs keep coming, so the block backs up
                fork
                    begin
                        hold_off = 1;
                        repeat (6000) @(posedge clk);
                        hold_off = 0;
                    end
                    for (int i = 0; i < 75; i++)
                        send_pair(pick_word(), pick_exponent());
                join
            end
            else
                for (int i = 0; i < 72; i++)
                    send_pair(pick_word(), pick_exponent());
            drain();
        end

        $display("Sent %0d base/exponent pairs over %0d key writes; %0d residues checked.",
                 items_sent, keys_written, residues_seen);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
